/* rtl/agent_velocity_collision_update_core_macros.svh */
// Assertion macros for the agent velocity collision update core.
`ifndef AGENT_VELOCITY_COLLISION_UPDATE_CORE_MACROS_SVH
`define AGENT_VELOCITY_COLLISION_UPDATE_CORE_MACROS_SVH

// checked outside reset only
`define AVCU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define AVCU_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/avcu_pkg.sv */
// Types, constants and helpers shared by the velocity update core.
package avcu_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 23;

  typedef enum logic [1:0] {
    CFG_MAX_SPEED   = 2'd0,
    CFG_MIN_SPEED   = 2'd1,
    CFG_RESTITUTION = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] acc_x;
    logic signed [23:0] acc_y;
    logic signed [23:0] normal_x;
    logic signed [23:0] normal_y;
    logic [15:0]        time_step;
  } in_t;

  typedef struct packed {
    logic signed [23:0] new_vel_x;
    logic signed [23:0] new_vel_y;
  } out_t;

  // velocity before the length clamp, travels alongside sqrt/div cells
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               scale;
    logic [22:0]        lim;
  } side_t;

  function automatic logic signed [31:0] sat_wide(input logic signed [48:0] v);
    if (v > 49'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -49'sh0_7FFF_FFFF) begin
      return -32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [23:0] sat_out(input logic signed [31:0] v);
    if (v > 32'sd8388607) begin
      return 24'sh7F_FFFF;
    end else if (v < -32'sd8388608) begin
      return 24'sh80_0000;
    end
    return v[23:0];
  endfunction

endpackage

/* rtl/avcu_sqrt_cell.sv */
// One digit step of the integer square root chain.
module avcu_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            vld_i,
  input  avcu_pkg::side_t side_i,
  input  logic [63:0]     rem_i,
  input  logic [63:0]     res_i,
  output logic            vld_o,
  output avcu_pkg::side_t side_o,
  output logic [63:0]     rem_o,
  output logic [63:0]     res_o
);
  import avcu_pkg::*;

  localparam int SH = 62 - 2 * STEP;

  logic [63:0] bitv;
  logic [63:0] trial;
  logic        take;
  logic        vld_r;
  side_t       side_r;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] res_r, res_nxt;

  assign bitv  = 64'd1 << SH;
  assign trial = res_i + bitv;
  assign take  = rem_i >= trial;

  always_comb begin
    rem_nxt = take ? rem_i - trial : rem_i;
    res_nxt = take ? (res_i >> 1) + bitv : res_i >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_i;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign rem_o  = rem_r;
  assign res_o  = res_r;

endmodule

/* rtl/avcu_div_cell.sv */
// One quotient bit of the two restoring dividers (x and y share the divisor).
module avcu_div_cell #(
  parameter int B = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            vld_i,
  input  avcu_pkg::side_t side_i,
  input  logic [31:0]     n_i,
  input  logic [54:0]     rx_i,
  input  logic [54:0]     ry_i,
  input  logic [22:0]     qx_i,
  input  logic [22:0]     qy_i,
  output logic            vld_o,
  output avcu_pkg::side_t side_o,
  output logic [31:0]     n_o,
  output logic [54:0]     rx_o,
  output logic [54:0]     ry_o,
  output logic [22:0]     qx_o,
  output logic [22:0]     qy_o
);
  import avcu_pkg::*;

  logic [54:0] dv;
  logic [22:0] qbit;
  logic        tx, ty;
  logic        vld_r;
  side_t       side_r;
  logic [31:0] n_r;
  logic [54:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [22:0] qx_r, qx_nxt, qy_r, qy_nxt;

  assign dv   = 55'(n_i) << B;
  assign qbit = 23'd1 << B;
  assign tx   = rx_i >= dv;
  assign ty   = ry_i >= dv;

  always_comb begin
    rx_nxt = tx ? rx_i - dv : rx_i;
    ry_nxt = ty ? ry_i - dv : ry_i;
    qx_nxt = tx ? qx_i | qbit : qx_i;
    qy_nxt = ty ? qy_i | qbit : qy_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_i;
    n_r    <= n_i;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign n_o    = n_r;
  assign rx_o   = rx_r;
  assign ry_o   = ry_r;
  assign qx_o   = qx_r;
  assign qy_o   = qy_r;

endmodule

/* rtl/agent_velocity_collision_update_core.sv */
// Top level: agent velocity update with collision impulse and speed clamp.
//
//   channel | ports                      | transfer when
//   --------+----------------------------+------------------------------
//   input   | start, busy, in_data       | start high, busy low
//   result  | out_valid, out_data        | out_valid high (one cycle)
//   config  | cfg_we, cfg_addr, cfg_data | cfg_we high
//
// One agent per cycle, sustained. An item passes from the input transfer to
// the result strobe through eight front stages, a 32-cell square root chain
// (one root digit per cell), one stage for the rescale numerator, a 23-cell
// divider chain (one quotient bit per cell) and the output register.
// busy stays low; reset (rst_n, synchronous) drops every item in flight.
// The receiver cannot stall, so nothing ever holds in the pipeline.
module agent_velocity_collision_update_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  avcu_pkg::in_t  in_data,
  output logic           out_valid,
  output avcu_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_addr,
  input  logic [22:0]    cfg_data
);
  import avcu_pkg::*;

  localparam int LAT = 8 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  // config registers
  logic [22:0] max_r, min_r;
  logic [8:0]  rest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= 23'd25600;
      min_r  <= 23'd5120;
      rest_r <= 9'd128;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_MAX_SPEED:   max_r  <= cfg_data;
        CFG_MIN_SPEED:   min_r  <= cfg_data;
        CFG_RESTITUTION: rest_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid line through the front stages
  logic [8:1] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[7:1], start};
    end
  end

  // S1: dot product terms and acc*dt
  in_t                in1_r, in2_r, in3_r, in4_r, in5_r;
  logic signed [47:0] px1_r, py1_r;
  logic signed [40:0] ax1_r, ay1_r;
  logic               nz1_r;

  always_ff @(posedge clk) begin
    in1_r <= in_data;
    px1_r <= in_data.vel_x * in_data.normal_x;
    py1_r <= in_data.vel_y * in_data.normal_y;
    ax1_r <= in_data.acc_x * $signed({1'b0, in_data.time_step});
    ay1_r <= in_data.acc_y * $signed({1'b0, in_data.time_step});
    nz1_r <= (in_data.normal_x == 24'sd0) && (in_data.normal_y == 24'sd0);
  end

  // S2: dot sum, integrated velocity, branch choice
  logic signed [48:0] dot;
  logic signed [40:0] axh, ayh;
  logic signed [48:0] dot2_r;
  logic signed [31:0] xi2_r, yi2_r, xi3_r, yi3_r, xi4_r, yi4_r, xi5_r, yi5_r;
  logic               ig2_r, ig3_r, ig4_r, ig5_r;

  assign dot = 49'(px1_r) + 49'(py1_r);
  assign axh = (ax1_r + 41'sd32768) >>> 16;
  assign ayh = (ay1_r + 41'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    in2_r  <= in1_r;
    dot2_r <= dot;
    xi2_r  <= 32'(in1_r.vel_x) + 32'(axh);
    yi2_r  <= 32'(in1_r.vel_y) + 32'(ayh);
    ig2_r  <= nz1_r || (dot > 49'sd0);
  end

  // S3: (1 + restitution) * -dot; only meaningful on the impulse path
  logic signed [48:0] nd;
  logic [57:0]        prod3_r;

  assign nd = -dot2_r;

  always_ff @(posedge clk) begin
    in3_r   <= in2_r;
    xi3_r   <= xi2_r;
    yi3_r   <= yi2_r;
    ig3_r   <= ig2_r;
    prod3_r <= 58'(nd[47:0]) * 58'({1'b0, rest_r} + 10'd256);
  end

  // S4: impulse magnitude, rounded and saturated
  logic [57:0] mr;
  logic [30:0] m4_r;

  assign mr = (prod3_r + 58'd32768) >> 16;

  always_ff @(posedge clk) begin
    in4_r <= in3_r;
    xi4_r <= xi3_r;
    yi4_r <= yi3_r;
    ig4_r <= ig3_r;
    m4_r  <= (mr > 58'h7FFF_FFFF) ? 31'h7FFF_FFFF : mr[30:0];
  end

  // S5: normal * m
  logic signed [55:0] imx5_r, imy5_r;

  always_ff @(posedge clk) begin
    in5_r  <= in4_r;
    xi5_r  <= xi4_r;
    yi5_r  <= yi4_r;
    ig5_r  <= ig4_r;
    imx5_r <= in4_r.normal_x * $signed({1'b0, m4_r});
    imy5_r <= in4_r.normal_y * $signed({1'b0, m4_r});
  end

  // S6: apply impulse, pick path
  logic signed [55:0] tx, ty;
  logic signed [31:0] xw, yw;
  logic signed [31:0] x6_r, y6_r, x7_r, y7_r;

  assign tx = (imx5_r + 56'sd128) >>> 8;
  assign ty = (imy5_r + 56'sd128) >>> 8;
  assign xw = sat_wide(49'(in5_r.vel_x) + 49'(tx));
  assign yw = sat_wide(49'(in5_r.vel_y) + 49'(ty));

  always_ff @(posedge clk) begin
    x6_r <= ig5_r ? xi5_r : xw;
    y6_r <= ig5_r ? yi5_r : yw;
  end

  // S7: squares of the magnitudes
  logic [31:0] ux, uy;
  logic [61:0] sqx7_r, sqy7_r;

  assign ux = x6_r[31] ? 32'(-x6_r) : 32'(x6_r);
  assign uy = y6_r[31] ? 32'(-y6_r) : 32'(y6_r);

  always_ff @(posedge clk) begin
    x7_r   <= x6_r;
    y7_r   <= y6_r;
    sqx7_r <= ux[30:0] * ux[30:0];
    sqy7_r <= uy[30:0] * uy[30:0];
  end

  // S8: length test against the limits
  logic [62:0] s;
  logic [45:0] maxsq, minsq;
  logic        gt, lt;
  side_t       sd8_r;
  logic [62:0] s8_r;

  assign s     = 63'(sqx7_r) + 63'(sqy7_r);
  assign maxsq = max_r * max_r;
  assign minsq = min_r * min_r;
  assign gt    = s > 63'(maxsq);
  assign lt    = s < 63'(minsq);

  always_ff @(posedge clk) begin
    sd8_r.x     <= x7_r;
    sd8_r.y     <= y7_r;
    sd8_r.scale <= (s != 63'd0) && (gt || lt);
    sd8_r.lim   <= gt ? max_r : min_r;
    s8_r        <= s;
  end

  // square root chain
  logic        vq   [0:SQRT_STEPS];
  side_t       sdq  [0:SQRT_STEPS];
  logic [63:0] remq [0:SQRT_STEPS];
  logic [63:0] resq [0:SQRT_STEPS];

  assign vq[0]   = v_r[8];
  assign sdq[0]  = sd8_r;
  assign remq[0] = 64'(s8_r);
  assign resq[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    avcu_sqrt_cell #(.STEP(k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vq[k]),
      .side_i (sdq[k]),
      .rem_i  (remq[k]),
      .res_i  (resq[k]),
      .vld_o  (vq[k+1]),
      .side_o (sdq[k+1]),
      .rem_o  (remq[k+1]),
      .res_o  (resq[k+1])
    );
  end

  // rescale numerators: |c| * limit + n/2
  side_t       sdq_end;
  logic [31:0] nq;
  logic [31:0] mx, my;
  logic        vm_r;
  side_t       sdm_r;
  logic [31:0] nm_r;
  logic [54:0] numx_r, numy_r;

  assign sdq_end = sdq[SQRT_STEPS];
  assign nq      = resq[SQRT_STEPS][31:0];
  assign mx      = sdq_end.x[31] ? 32'(-sdq_end.x) : 32'(sdq_end.x);
  assign my      = sdq_end.y[31] ? 32'(-sdq_end.y) : 32'(sdq_end.y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else begin
      vm_r <= vq[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    sdm_r  <= sdq_end;
    nm_r   <= nq;
    numx_r <= 55'(mx[30:0] * sdq_end.lim) + 55'(nq >> 1);
    numy_r <= 55'(my[30:0] * sdq_end.lim) + 55'(nq >> 1);
  end

  // divider chain, quotient MSB first
  logic        vd  [0:DIV_STEPS];
  side_t       sdd [0:DIV_STEPS];
  logic [31:0] nd_c[0:DIV_STEPS];
  logic [54:0] rxd [0:DIV_STEPS];
  logic [54:0] ryd [0:DIV_STEPS];
  logic [22:0] qxd [0:DIV_STEPS];
  logic [22:0] qyd [0:DIV_STEPS];

  assign vd[0]   = vm_r;
  assign sdd[0]  = sdm_r;
  assign nd_c[0] = nm_r;
  assign rxd[0]  = numx_r;
  assign ryd[0]  = numy_r;
  assign qxd[0]  = '0;
  assign qyd[0]  = '0;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    avcu_div_cell #(.B(DIV_STEPS - 1 - k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vd[k]),
      .side_i (sdd[k]),
      .n_i    (nd_c[k]),
      .rx_i   (rxd[k]),
      .ry_i   (ryd[k]),
      .qx_i   (qxd[k]),
      .qy_i   (qyd[k]),
      .vld_o  (vd[k+1]),
      .side_o (sdd[k+1]),
      .n_o    (nd_c[k+1]),
      .rx_o   (rxd[k+1]),
      .ry_o   (ryd[k+1]),
      .qx_o   (qxd[k+1]),
      .qy_o   (qyd[k+1])
    );
  end

  // output: signed quotient when rescaled, else saturated velocity
  side_t              sdd_end;
  logic signed [23:0] qxs, qys;
  logic               out_valid_r;
  out_t               out_data_r;

  assign sdd_end = sdd[DIV_STEPS];
  assign qxs     = $signed({1'b0, qxd[DIV_STEPS]});
  assign qys     = $signed({1'b0, qyd[DIV_STEPS]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vd[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (sdd_end.scale) begin
      out_data_r.new_vel_x <= sdd_end.x[31] ? -qxs : qxs;
      out_data_r.new_vel_y <= sdd_end.y[31] ? -qys : qys;
    end else begin
      out_data_r.new_vel_x <= sat_out(sdd_end.x);
      out_data_r.new_vel_y <= sat_out(sdd_end.y);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "agent_velocity_collision_update_core_macros.svh"

  // every accepted item gives a result strobe, and no strobe comes without an item
`AVCU_ASSERT_RST(a_item_out, start |-> ##LAT out_valid, "accepted item gave no result")
`AVCU_ASSERT_RST(a_no_stray, out_valid |-> $past(start, LAT), "result without an item")
`AVCU_ASSERT_CLK(a_rst_flush, !rst_n |=> !out_valid, "result strobe right after reset")

endmodule
